[rtl/tglq_pkg.sv]
// Shared types, character codes and saturating helpers for the glyph quad layout block.
`default_nettype none

package tglq_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Pen steps keep the full tab product so the pen update saturates once
  localparam int unsigned STEP_W = 36;
  localparam logic signed [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};

  localparam int unsigned VERTS_PER_GLYPH = 6;
  localparam int unsigned VERT_IDX_W      = $clog2(VERTS_PER_GLYPH);

  localparam logic [1:0] ADDR_START_BASELINE_Y = 2'd0;

  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_VT     = 8'd11;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;

  typedef enum logic [2:0] {
    CHR_GLYPH,
    CHR_LF,
    CHR_VT,
    CHR_CR,
    CHR_SPACE,
    CHR_TAB
  } chr_e;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               string_start;
    logic signed [31:0] glyph_bearing_x;
    logic signed [31:0] glyph_bearing_y;
    logic signed [31:0] glyph_width;
    logic signed [31:0] glyph_height;
    logic signed [31:0] glyph_advance;
    logic [15:0]        tex_left;
    logic [15:0]        tex_top;
    logic [15:0]        tex_right;
    logic [15:0]        tex_bottom;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        vertex_u;
    logic [15:0]        vertex_v;
    logic               last_vertex;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } out_item_t;

  // Per-character metrics after preparation, ready for the pen update
  typedef struct packed {
    chr_e                     cls;
    logic                     start;
    logic signed [31:0]       bx;
    logic signed [31:0]       by;
    logic signed [31:0]       w;
    logic signed [31:0]       h;
    logic signed [31:0]       hang;
    logic signed [STEP_W-1:0] adv_step;
    logic signed [STEP_W-1:0] y_step;
    logic [15:0]              tl;
    logic [15:0]              tt;
    logic [15:0]              tr;
    logic [15:0]              tb;
  } met_t;

  // Quad corners handed from the pen stage to the vertex emitter
  typedef struct packed {
    logic               clear;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
  } crn_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? Q_MIN : Q_MAX;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_wide(input logic signed [STEP_W:0] v);
    if (v[STEP_W:31] == '0 || v[STEP_W:31] == '1) begin
      return v[31:0];
    end
    return v[STEP_W] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33(33'(a) - 33'(b));
  endfunction

endpackage

`default_nettype wire

[rtl/tglq_metric.sv]
// Input register and three-step preparation of hang, line step and pen advance.
`default_nettype none

module tglq_metric import tglq_pkg::*; #(
  parameter int unsigned TAB_SPACES = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          met_valid_o,
  input  wire logic     met_ready_i,
  output met_t          met_o
);

  localparam int unsigned TW = $clog2(TAB_SPACES + 1);
  localparam int unsigned PW = STEP_W + TW;
  localparam logic signed [TW:0] TabMul = (TW + 1)'(TAB_SPACES);

  function automatic logic signed [STEP_W-1:0] sat_tab(input logic signed [31:0] a);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(TabMul);
    if (p[PW-1:STEP_W-1] == '0 || p[PW-1:STEP_W-1] == '1) begin
      return p[STEP_W-1:0];
    end
    return p[PW-1] ? STEP_MIN : STEP_MAX;
  endfunction

  function automatic chr_e decode(input logic [7:0] c);
    case (c)
      CHAR_LF:    return CHR_LF;
      CHAR_VT:    return CHR_VT;
      CHAR_CR:    return CHR_CR;
      CHAR_SPACE: return CHR_SPACE;
      CHAR_TAB:   return CHR_TAB;
      default:    return CHR_GLYPH;
    endcase
  endfunction

  logic     in_vld_q, in_vld_d;
  logic     s1_vld_q, s1_vld_d;
  logic     s2_vld_q, s2_vld_d;
  logic     s3_vld_q, s3_vld_d;
  in_item_t in_q;
  met_t     s1_q, s1_d;
  met_t     s2_q, s2_d;
  met_t     s3_q, s3_d;
  logic     in_rdy, s1_rdy, s2_rdy, s3_rdy;
  logic     in_ld, s1_ld, s2_ld, s3_ld;
  logic signed [33:0] line_sum;
  logic signed [31:0] line_sat;

  assign s3_rdy = !s3_vld_q || met_ready_i;
  assign s2_rdy = !s2_vld_q || s3_rdy;
  assign s1_rdy = !s1_vld_q || s2_rdy;
  assign in_rdy = !in_vld_q || s1_rdy;

  assign in_ld = in_valid_i && in_rdy;
  assign s1_ld = in_vld_q && s1_rdy;
  assign s2_ld = s1_vld_q && s2_rdy;
  assign s3_ld = s2_vld_q && s3_rdy;

  assign in_vld_d = in_ld || (in_vld_q && !s1_ld);
  assign s1_vld_d = s1_ld || (s1_vld_q && !s2_ld);
  assign s2_vld_d = s2_ld || (s2_vld_q && !s3_ld);
  assign s3_vld_d = s3_ld || (s3_vld_q && !met_ready_i);

  assign in_stall_o  = !in_rdy;
  assign met_valid_o = s3_vld_q;
  assign met_o       = s3_q;

  always_comb begin
    s1_d          = '0;
    s1_d.cls      = decode(in_q.char_code);
    s1_d.start    = in_q.string_start;
    s1_d.bx       = in_q.glyph_bearing_x;
    s1_d.by       = in_q.glyph_bearing_y;
    s1_d.w        = in_q.glyph_width;
    s1_d.h        = in_q.glyph_height;
    s1_d.hang     = sat_sub(in_q.glyph_bearing_y, in_q.glyph_height);
    s1_d.adv_step = (s1_d.cls == CHR_TAB) ? sat_tab(in_q.glyph_advance)
                                          : STEP_W'(in_q.glyph_advance);
    s1_d.tl       = in_q.tex_left;
    s1_d.tt       = in_q.tex_top;
    s1_d.tr       = in_q.tex_right;
    s1_d.tb       = in_q.tex_bottom;
  end

  assign line_sum = {s1_q.by[31], s1_q.by, 1'b0} + 34'(s1_q.hang);

  always_comb begin
    s2_d = s1_q;
    if (line_sum[33:31] == 3'b000 || line_sum[33:31] == 3'b111) begin
      line_sat = line_sum[31:0];
    end else begin
      line_sat = line_sum[33] ? Q_MIN : Q_MAX;
    end
    s2_d.y_step = STEP_W'(line_sat);
  end

  always_comb begin
    s3_d = s2_q;
    if (s2_q.cls == CHR_VT) begin
      s3_d.y_step = sat_tab(s2_q.y_step[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      s3_vld_q <= s3_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ld) begin
      in_q <= in_data_i;
    end
    if (s1_ld) begin
      s1_q <= s1_d;
    end
    if (s2_ld) begin
      s2_q <= s2_d;
    end
    if (s3_ld) begin
      s3_q <= s3_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tglq_pen.sv]
// Pen position state, whitespace handling and first quad corner.
`default_nettype none

module tglq_pen import tglq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic signed [31:0] start_baseline_y_i,
  input  wire logic        met_valid_i,
  output logic             met_ready_o,
  input  wire met_t        met_i,
  output logic             crn_valid_o,
  input  wire logic        crn_ready_i,
  output crn_t             crn_o
);

  logic signed [31:0] pen_x_q, pen_x_d;
  logic signed [31:0] pen_y_q, pen_y_d;
  logic               clr_pend_q, clr_pend_d;
  logic               crn_vld_q, crn_vld_d;
  crn_t               crn_q, crn_d;
  logic signed [31:0] px, py;
  logic               is_ws, crn_rdy, take, crn_ld;

  assign is_ws   = (met_i.cls != CHR_GLYPH);
  assign crn_rdy = !crn_vld_q || crn_ready_i;
  assign met_ready_o = is_ws || crn_rdy;
  assign take    = met_valid_i && met_ready_o;
  assign crn_ld  = take && !is_ws;

  assign px = met_i.start ? 32'sd0 : pen_x_q;
  assign py = met_i.start ? start_baseline_y_i : pen_y_q;

  always_comb begin
    pen_x_d    = pen_x_q;
    pen_y_d    = pen_y_q;
    clr_pend_d = clr_pend_q;
    if (take) begin
      pen_x_d    = px;
      pen_y_d    = py;
      clr_pend_d = is_ws ? (clr_pend_q || met_i.start) : 1'b0;
      case (met_i.cls)
        CHR_LF, CHR_VT: begin
          pen_y_d = sat_wide((STEP_W + 1)'(py) - (STEP_W + 1)'(met_i.y_step));
          pen_x_d = 32'sd0;
        end
        CHR_CR: begin
          pen_x_d = 32'sd0;
        end
        CHR_SPACE, CHR_TAB, CHR_GLYPH: begin
          pen_x_d = sat_wide((STEP_W + 1)'(px) + (STEP_W + 1)'(met_i.adv_step));
        end
        default: begin
          pen_x_d = px;
        end
      endcase
    end
  end

  always_comb begin
    crn_d.clear = clr_pend_q || met_i.start;
    crn_d.x0    = sat_add(px, met_i.bx);
    crn_d.y0    = sat_add(py, met_i.hang);
    crn_d.w     = met_i.w;
    crn_d.h     = met_i.h;
    crn_d.tl    = met_i.tl;
    crn_d.tt    = met_i.tt;
    crn_d.tr    = met_i.tr;
    crn_d.tb    = met_i.tb;
  end

  assign crn_vld_d   = crn_ld || (crn_vld_q && !crn_ready_i);
  assign crn_valid_o = crn_vld_q;
  assign crn_o       = crn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q    <= '0;
      pen_y_q    <= '0;
      clr_pend_q <= 1'b0;
      crn_vld_q  <= 1'b0;
    end else begin
      pen_x_q    <= pen_x_d;
      pen_y_q    <= pen_y_d;
      clr_pend_q <= clr_pend_d;
      crn_vld_q  <= crn_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (crn_ld) begin
      crn_q <= crn_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tglq_emit.sv]
// Far quad corner, six-vertex sequencer, running bounding box and output register.
`default_nettype none

module tglq_emit import tglq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic crn_valid_i,
  output logic      crn_ready_o,
  input  wire crn_t crn_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  typedef struct packed {
    logic               clear;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
  } quad_t;

  localparam logic [VERT_IDX_W-1:0] LastIdx = VERT_IDX_W'(VERTS_PER_GLYPH - 1);

  quad_t                 quad_q, quad_d;
  logic                  quad_vld_q, quad_vld_d;
  logic [VERT_IDX_W-1:0] cnt_q, cnt_d;
  logic                  out_vld_q, out_vld_d;
  out_item_t             out_q, out_d;
  logic signed [31:0]    min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [31:0]    min_x_b, min_y_b, max_x_b, max_y_b;
  logic signed [31:0]    vx, vy;
  logic [15:0]           vu, vv;
  logic                  out_rdy, emit, last, quad_ld;

  assign out_rdy = !out_vld_q || !out_stall_i;
  assign emit    = quad_vld_q && out_rdy;
  assign last    = (cnt_q == LastIdx);
  assign crn_ready_o = !quad_vld_q || (emit && last);
  assign quad_ld = crn_valid_i && crn_ready_o;

  always_comb begin
    quad_d.clear = crn_i.clear;
    quad_d.x0    = crn_i.x0;
    quad_d.y0    = crn_i.y0;
    quad_d.x1    = sat_add(crn_i.x0, crn_i.w);
    quad_d.y1    = sat_add(crn_i.y0, crn_i.h);
    quad_d.tl    = crn_i.tl;
    quad_d.tt    = crn_i.tt;
    quad_d.tr    = crn_i.tr;
    quad_d.tb    = crn_i.tb;
  end

  assign quad_vld_d = quad_ld || (quad_vld_q && !(emit && last));
  assign cnt_d      = emit ? (last ? '0 : cnt_q + 1'b1) : cnt_q;
  assign out_vld_d  = emit || (out_vld_q && out_stall_i);

  always_comb begin
    case (cnt_q)
      3'd0: begin
        vx = quad_q.x0; vy = quad_q.y1; vu = quad_q.tl; vv = quad_q.tt;
      end
      3'd1, 3'd4: begin
        vx = quad_q.x0; vy = quad_q.y0; vu = quad_q.tl; vv = quad_q.tb;
      end
      3'd2, 3'd3: begin
        vx = quad_q.x1; vy = quad_q.y1; vu = quad_q.tr; vv = quad_q.tt;
      end
      default: begin
        vx = quad_q.x1; vy = quad_q.y0; vu = quad_q.tr; vv = quad_q.tb;
      end
    endcase
  end

  always_comb begin
    if (quad_q.clear && cnt_q == '0) begin
      min_x_b = Q_MAX;
      min_y_b = Q_MAX;
      max_x_b = Q_MIN;
      max_y_b = Q_MIN;
    end else begin
      min_x_b = min_x_q;
      min_y_b = min_y_q;
      max_x_b = max_x_q;
      max_y_b = max_y_q;
    end
    out_d.vertex_x    = vx;
    out_d.vertex_y    = vy;
    out_d.vertex_u    = vu;
    out_d.vertex_v    = vv;
    out_d.last_vertex = last;
    out_d.box_min_x   = (vx < min_x_b) ? vx : min_x_b;
    out_d.box_min_y   = (vy < min_y_b) ? vy : min_y_b;
    out_d.box_max_x   = (vx > max_x_b) ? vx : max_x_b;
    out_d.box_max_y   = (vy > max_y_b) ? vy : max_y_b;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      min_x_q    <= Q_MAX;
      min_y_q    <= Q_MAX;
      max_x_q    <= Q_MIN;
      max_y_q    <= Q_MIN;
    end else begin
      quad_vld_q <= quad_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      if (emit) begin
        min_x_q <= out_d.box_min_x;
        min_y_q <= out_d.box_min_y;
        max_x_q <= out_d.box_max_x;
        max_y_q <= out_d.box_max_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_ld) begin
      quad_q <= quad_d;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[rtl/text_glyph_quad_layout_core.sv]
// Top level of the glyph quad layout block: register port and stage wiring.
//
// Usage: one character per input transaction, with its glyph metrics, on a
// valid/stall channel. Characters other than the five below give six vertex transactions
// (two triangles) on the output channel, each with the running bounding
// box; line feed, vertical tab, carriage return, space and tab only move
// the pen and give no output. string_start homes the pen to
// (0, start_baseline_y) and clears the box before its character.
// The emitter sends the vertices of a glyph from its single vertex output
// register and takes the next glyph while sending the sixth; whitespace is
// taken one per cycle unless a held glyph ahead of it stalls the stages.
// A stalled output holds its vertex; the stall backs up through the quad,
// corner, three preparation and input registers before in_stall_o rises.
// Reset empties all stages, puts the pen at (0, 0), the box at its empty
// extremes and start_baseline_y at 0. Write the register only while idle.
`default_nettype none

module text_glyph_quad_layout_core import tglq_pkg::*; #(
  parameter int unsigned TAB_SPACES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [31:0] start_y_q, start_y_d;
  logic               cfg_wr;
  logic               met_valid, met_ready;
  met_t               met;
  logic               crn_valid, crn_ready;
  crn_t               crn;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_START_BASELINE_Y);
  assign start_y_d = cfg_wr ? pwdata : start_y_q;
  assign prdata = (paddr == ADDR_START_BASELINE_Y) ? start_y_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_y_q <= '0;
    end else begin
      start_y_q <= start_y_d;
    end
  end

  tglq_metric #(
    .TAB_SPACES (TAB_SPACES)
  ) u_metric (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .met_valid_o (met_valid),
    .met_ready_i (met_ready),
    .met_o       (met)
  );

  tglq_pen u_pen (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_baseline_y_i (start_y_q),
    .met_valid_i        (met_valid),
    .met_ready_o        (met_ready),
    .met_i              (met),
    .crn_valid_o        (crn_valid),
    .crn_ready_i        (crn_ready),
    .crn_o              (crn)
  );

  tglq_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .crn_valid_i (crn_valid),
    .crn_ready_o (crn_ready),
    .crn_i       (crn),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the glyph quad layout block: directed table, then random strings.
`default_nettype none

module tb;
  import tglq_pkg::*;

  localparam int TAB_SPACES = 4;
  localparam int ONE = 32'h0001_0000;
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_FF = 8'd12;
  localparam logic [7:0] CHAR_TOP = 8'd255;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  text_glyph_quad_layout_core #(.TAB_SPACES(TAB_SPACES)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [31:0] baseline_y = '0;
  logic signed [31:0] pen_x = '0;
  logic signed [31:0] pen_y = '0;
  logic signed [31:0] min_x = Q_MAX;
  logic signed [31:0] min_y = Q_MAX;
  logic signed [31:0] max_x = Q_MIN;
  logic signed [31:0] max_y = Q_MIN;
  out_item_t vertex_q[$];
  int mismatches = 0;
  bit calm = 1'b0;
  out_item_t want;

  function automatic logic signed [31:0] clamp(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic void add_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                     logic [15:0] u, logic [15:0] v, logic last);
    out_item_t vx;
    if (x < min_x) min_x = x;
    if (y < min_y) min_y = y;
    if (x > max_x) max_x = x;
    if (y > max_y) max_y = y;
    vx.vertex_x = x;
    vx.vertex_y = y;
    vx.vertex_u = u;
    vx.vertex_v = v;
    vx.last_vertex = last;
    vx.box_min_x = min_x;
    vx.box_min_y = min_y;
    vx.box_max_x = max_x;
    vx.box_max_y = max_y;
    vertex_q.push_back(vx);
  endfunction

  function automatic void lay_out_glyph(in_item_t it);
    logic signed [31:0] bx, by, w, h, adv, hang, line, x0, y0, x1, y1;
    bx = it.glyph_bearing_x;
    by = it.glyph_bearing_y;
    w = it.glyph_width;
    h = it.glyph_height;
    adv = it.glyph_advance;
    if (it.string_start) begin
      pen_x = '0;
      pen_y = baseline_y;
      min_x = Q_MAX;
      min_y = Q_MAX;
      max_x = Q_MIN;
      max_y = Q_MIN;
    end
    hang = clamp(longint'(by) - longint'(h));
    line = clamp(2 * longint'(by) + longint'(hang));
    case (it.char_code)
      CHAR_LF: begin
        pen_y = clamp(longint'(pen_y) - longint'(line));
        pen_x = '0;
      end
      CHAR_VT: begin
        pen_y = clamp(longint'(pen_y) - longint'(line) * TAB_SPACES);
        pen_x = '0;
      end
      CHAR_CR: pen_x = '0;
      CHAR_SPACE: pen_x = clamp(longint'(pen_x) + longint'(adv));
      CHAR_TAB: pen_x = clamp(longint'(pen_x) + longint'(adv) * TAB_SPACES);
      default: begin
        x0 = clamp(longint'(pen_x) + longint'(bx));
        y0 = clamp(longint'(pen_y) + longint'(hang));
        x1 = clamp(longint'(x0) + longint'(w));
        y1 = clamp(longint'(y0) + longint'(h));
        pen_x = clamp(longint'(pen_x) + longint'(adv));
        add_vertex(x0, y1, it.tex_left, it.tex_top, 1'b0);
        add_vertex(x0, y0, it.tex_left, it.tex_bottom, 1'b0);
        add_vertex(x1, y1, it.tex_right, it.tex_top, 1'b0);
        add_vertex(x1, y1, it.tex_right, it.tex_top, 1'b0);
        add_vertex(x0, y0, it.tex_left, it.tex_bottom, 1'b0);
        add_vertex(x1, y0, it.tex_right, it.tex_bottom, 1'b1);
      end
    endcase
  endfunction

  function automatic in_item_t mk(logic [7:0] c, logic st, int bx, int by, int w, int h,
                                  int adv, logic [63:0] tex);
    in_item_t it;
    it.char_code = c;
    it.string_start = st;
    it.glyph_bearing_x = bx;
    it.glyph_bearing_y = by;
    it.glyph_width = w;
    it.glyph_height = h;
    it.glyph_advance = adv;
    {it.tex_left, it.tex_top, it.tex_right, it.tex_bottom} = tex;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_metric();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
  endfunction

  function automatic in_item_t rand_char(bit st);
    logic [7:0] c;
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      10: c = CHAR_LF;
      11: c = CHAR_VT;
      12: c = CHAR_CR;
      13: c = CHAR_SPACE;
      14: c = CHAR_TAB;
      15: c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(33, 126));
    endcase
    return mk(c, st, rand_metric(), rand_metric(), rand_metric(), rand_metric(),
              rand_metric(), {$urandom, $urandom});
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    lay_out_glyph(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_START_BASELINE_Y;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_baseline(logic signed [31:0] value);
    logic [31:0] rd;
    reg_access(1'b1, value, rd);
    baseline_y = value;
    reg_access(1'b0, '0, rd);
    if (rd !== value) begin
      $display("%0t start_baseline_y readback: expected %h, got %h", $time, value, rd);
      mismatches++;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t vertex %s: expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $display("%0t unexpected vertex: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = vertex_q.pop_front();
        check_field("x", want.vertex_x, out_data.vertex_x);
        check_field("y", want.vertex_y, out_data.vertex_y);
        check_field("u", 32'(want.vertex_u), 32'(out_data.vertex_u));
        check_field("v", 32'(want.vertex_v), 32'(out_data.vertex_v));
        check_field("last", 32'(want.last_vertex), 32'(out_data.last_vertex));
        check_field("box_min_x", want.box_min_x, out_data.box_min_x);
        check_field("box_min_y", want.box_min_y, out_data.box_min_y);
        check_field("box_max_x", want.box_max_x, out_data.box_max_x);
        check_field("box_max_y", want.box_max_y, out_data.box_max_y);
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    in_item_t dir_items[];
    out_item_t typed_last[int];
    logic signed [31:0] phase_base[6];
    dir_items = '{
      mk("A", 1'b1, ONE, 2*ONE, 3*ONE, ONE, 4*ONE, 64'h1000_2000_3000_4000),
      mk("B", 1'b0, 0, 2*ONE, 2*ONE, 2*ONE, 3*ONE, 64'h0800_0100_1800_0F00),
      mk(CHAR_SPACE, 1'b0, 0, 0, 0, 0, 2*ONE, 64'h0),
      mk(CHAR_TAB, 1'b0, 0, 0, 0, 0, ONE, 64'h0),
      mk("C", 1'b0, 32'h8000, 3*ONE, ONE, 2*ONE, 32'h0001_8000, 64'h1234_5678_9ABC_DEF0),
      mk(CHAR_LF, 1'b0, 0, 2*ONE, 0, ONE, 0, 64'h0),
      mk(CHAR_VT, 1'b0, 0, 2*ONE, 0, ONE, 0, 64'h0),
      mk(CHAR_CR, 1'b0, 0, 0, 0, 0, 0, 64'h0),
      mk(CHAR_FF, 1'b0, ONE, ONE, ONE, ONE, ONE, 64'h0100_0200_0300_0400),
      mk(CHAR_NUL, 1'b0, ONE, 2*ONE, ONE, ONE, ONE, 64'h0500_0600_0700_0800),
      mk(CHAR_TOP, 1'b0, 0, ONE, 2*ONE, ONE, 2*ONE, 64'h0900_0A00_0B00_0C00),
      mk("n", 1'b0, -ONE, ONE, -3*ONE, -2*ONE, -ONE, 64'h4000_3000_2000_1000),
      mk("M", 1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 64'hFFFF_FFFF_FFFF_FFFF),
      mk("m", 1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 64'h0),
      mk(CHAR_SPACE, 1'b0, 0, 0, 0, 0, Q_MAX, 64'h0),
      mk("x", 1'b0, ONE, ONE, ONE, ONE, Q_MAX, 64'h1111_2222_3333_4444),
      mk(CHAR_TAB, 1'b1, 0, 0, 0, 0, Q_MIN, 64'h0),
      mk(CHAR_VT, 1'b0, 0, Q_MAX, 0, Q_MIN, 0, 64'h0),
      mk(CHAR_LF, 1'b0, 0, Q_MIN, 0, Q_MAX, 0, 64'h0),
      mk(CHAR_LF, 1'b1, 0, ONE, 0, 0, 0, 64'h0),
      mk("Z", 1'b0, 32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hAAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF),
      mk(CHAR_CR, 1'b1, 0, 0, 0, 0, 0, 64'h0),
      mk("q", 1'b0, ONE, 2*ONE, ONE, 3*ONE, ONE, 64'h0010_0020_0030_0040)
    };
    typed_last[0] = '{vertex_x: 32'h0004_0000, vertex_y: 32'h0001_0000, vertex_u: 16'h3000,
                      vertex_v: 16'h4000, last_vertex: 1'b1, box_min_x: 32'h0001_0000,
                      box_min_y: 32'h0001_0000, box_max_x: 32'h0004_0000,
                      box_max_y: 32'h0002_0000};
    typed_last[12] = '{vertex_x: Q_MAX, vertex_y: Q_MAX, vertex_u: 16'hFFFF,
                       vertex_v: 16'hFFFF, last_vertex: 1'b1, box_min_x: Q_MAX,
                       box_min_y: 32'hFFFF_FFFF, box_max_x: Q_MAX, box_max_y: Q_MAX};
    typed_last[13] = '{vertex_x: Q_MIN, vertex_y: Q_MIN, vertex_u: 16'h0000,
                       vertex_v: 16'h0000, last_vertex: 1'b1, box_min_x: Q_MIN,
                       box_min_y: Q_MIN, box_max_x: Q_MIN, box_max_y: 32'hFFFF_FFFF};
    phase_base = '{Q_MAX, Q_MIN, $urandom, 32'h0020_0000, $urandom, 32'h0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, pen starting from the reset baseline
    foreach (dir_items[i]) begin
      send(dir_items[i]);
      if (typed_last.exists(i)) vertex_q[vertex_q.size() - 1] = typed_last[i];
    end
    drain();

    // random strings, one baseline per phase; some phases run without idling
    foreach (phase_base[p]) begin
      set_baseline(phase_base[p]);
      calm = (p % 3 == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send(rand_char(k == 0 || $urandom_range(0, 9) == 0));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/tglq_pkg.sv
rtl/tglq_metric.sv
rtl/tglq_pen.sv
rtl/tglq_emit.sv
rtl/text_glyph_quad_layout_core.sv
verif/tb.sv
